@@ design/tsal_pkg.sv @@
// ----------------------------------------------------------------------------
// tsal_pkg: shared types and constants of the square-array locator
// Word formats, status codes and the internal widths of the datapath.
// ----------------------------------------------------------------------------
package tsal_pkg;

  localparam int TIME_WIDTH = 16;
  localparam int XY_WIDTH   = 24;
  localparam int SS_WIDTH   = 10;
  localparam int HS_WIDTH   = 16;
  localparam int CFG_WIDTH  = 16;
  localparam int IDX_WIDTH  = 2;

  // Time differences and the products built from them.
  localparam int DW  = TIME_WIDTH + 1;
  localparam int EW  = DW + 1;
  localparam int MW  = DW + EW;
  localparam int XW  = MW + 1;
  localparam int PW  = DW + XW;
  localparam int C2W = 2 * SS_WIDTH;
  localparam int NW  = PW + C2W + 1;
  localparam int SW  = DW + 2;
  localparam int KW  = HS_WIDTH + 22;
  localparam int DNW = SW + KW + 1;
  localparam int RW  = DNW + XY_WIDTH;

  localparam logic [21:0] MICRO_SCALE = 22'd4000000;

  localparam logic [IDX_WIDTH-1:0] REG_SOUND_SPEED = 2'd0;
  localparam logic [IDX_WIDTH-1:0] REG_HALF_SIDE   = 2'd1;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_ZERO_DEN  = 2'd1;
  localparam logic [1:0] STATUS_SATURATED = 2'd2;

  typedef struct packed {
    logic [TIME_WIDTH-1:0] time_a;
    logic [TIME_WIDTH-1:0] time_b;
    logic [TIME_WIDTH-1:0] time_c;
    logic [TIME_WIDTH-1:0] time_d;
  } in_word_t;

  typedef struct packed {
    logic signed [XY_WIDTH-1:0] x_mm;
    logic signed [XY_WIDTH-1:0] y_mm;
    logic [1:0]                 status;
  } out_word_t;

endpackage

@@ design/tdoa_square_array_locator.sv @@
// ----------------------------------------------------------------------------
// tdoa_square_array_locator: four-microphone square-array source locator
// Turns four arrival timestamps into a saturated x/y position in millimetres.
// ----------------------------------------------------------------------------
// The block takes one word of four arrival times (microseconds, microphones
// A to D at the corners of a square of side 2L) per cycle while the output is
// not stalled and returns one position word per input word, in input order.
// Six stages form the time differences, the products, the signed
// numerators and the divisor, and check the quotient against the
// 24-bit range; then 24 restoring-division stages produce one quotient bit
// each for x and y side by side; a last register holds the result word.
// The whole pipeline advances whenever the output register is empty or being
// read, so a stall at the output freezes every stage and nothing is lost or
// repeated. Configuration (sound speed in
// m/s at index 0, half side in mm at index 1) may only be written while no
// word is in flight. A zero divisor reports status 1 with x and y zero; a
// coordinate outside the 24-bit range saturates and reports status 2.
module tdoa_square_array_locator (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  tsal_pkg::in_word_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output tsal_pkg::out_word_t           out_data,
  input  logic                          cfg_we,
  input  logic [tsal_pkg::IDX_WIDTH-1:0] cfg_index,
  input  logic [tsal_pkg::CFG_WIDTH-1:0] cfg_data
);
  import tsal_pkg::*;

  localparam int QB = XY_WIDTH;

  logic [SS_WIDTH-1:0] sound_speed;
  logic [HS_WIDTH-1:0] half_side;
  logic adv;

  // Stage valid bits.
  logic v1, v2, v3, v4, v5;
  logic vd [0:QB];

  // Stage 1: time differences against microphone A.
  logic signed [DW-1:0] d2_1, d3_1, d4_1;
  // Stage 2: difference products, divisor sum, scaled constants.
  logic signed [MW-1:0] m1_2, m2_2, n1_2, n2_2;
  logic signed [DW-1:0] d2_2, d4_2;
  logic signed [SW-1:0] s_2;
  logic [C2W-1:0]       c2_2;
  logic [KW-1:0]        k_2;
  // Stage 3: partial numerators and the signed divisor.
  logic signed [PW-1:0]  px_3, py_3;
  logic signed [DNW-1:0] den_3;
  logic [C2W-1:0]        c2_3;
  // Stage 4: full numerators.
  logic signed [NW-1:0]  nx_4, ny_4;
  logic signed [DNW-1:0] den_4;
  // Stage 5: magnitudes and signs.
  logic [NW-1:0]  ax_5, ay_5;
  logic [DNW-1:0] dm_5;
  logic nxneg_5, nyneg_5, dneg_5, dzero_5;

  // Division stages, index 0 is fed by the range check stage.
  logic [RW-1:0]  rx [0:QB];
  logic [RW-1:0]  ry [0:QB];
  logic [QB-1:0]  qx [0:QB];
  logic [QB-1:0]  qy [0:QB];
  logic [DNW-1:0] dm [0:QB];
  logic           negx [0:QB];
  logic           negy [0:QB];
  logic           ovx [0:QB];
  logic           ovy [0:QB];
  logic           dz [0:QB];

  logic signed [EW-1:0] t32, t42, t34, t24;
  logic signed [XW-1:0] ex, ey;
  logic [RW-1:0]        dshift;
  logic                 satx, saty;
  out_word_t            res;

  // No word is taken while reset is held.
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv && !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      sound_speed <= SS_WIDTH'(340);
      half_side   <= HS_WIDTH'(1000);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SOUND_SPEED: sound_speed <= cfg_data[SS_WIDTH-1:0];
        REG_HALF_SIDE:   half_side   <= cfg_data[HS_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    t32 = d3_1 - d2_1;
    t42 = d4_1 - d2_1;
    t34 = d3_1 - d4_1;
    t24 = d2_1 - d4_1;
    ex  = m1_2 - m2_2;
    ey  = n1_2 - n2_2;
    dshift = RW'(dm_5) << QB;
  end

  // Valid bits of the front stages and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      vd[0] <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      vd[0] <= v5;
      out_valid <= vd[QB];
    end
  end

  // Front datapath: at most one multiply level per stage.
  always_ff @(posedge clk) begin
    if (adv) begin
      d2_1 <= $signed({1'b0, in_data.time_b}) - $signed({1'b0, in_data.time_a});
      d3_1 <= $signed({1'b0, in_data.time_c}) - $signed({1'b0, in_data.time_a});
      d4_1 <= $signed({1'b0, in_data.time_d}) - $signed({1'b0, in_data.time_a});

      m1_2 <= d3_1 * t32;
      m2_2 <= d4_1 * t42;
      n1_2 <= d3_1 * t34;
      n2_2 <= d2_1 * t24;
      s_2  <= d4_1 - d3_1 + d2_1;
      d2_2 <= d2_1;
      d4_2 <= d4_1;
      c2_2 <= sound_speed * sound_speed;
      k_2  <= half_side * MICRO_SCALE;

      px_3  <= d2_2 * ex;
      py_3  <= d4_2 * ey;
      den_3 <= s_2 * $signed({1'b0, k_2});
      c2_3  <= c2_2;

      nx_4  <= $signed({1'b0, c2_3}) * px_3;
      ny_4  <= $signed({1'b0, c2_3}) * py_3;
      den_4 <= den_3;

      nxneg_5 <= nx_4[NW-1];
      nyneg_5 <= ny_4[NW-1];
      dneg_5  <= den_4[DNW-1];
      dzero_5 <= (den_4 == '0);
      ax_5    <= nx_4[NW-1] ? NW'(-nx_4) : NW'(nx_4);
      ay_5    <= ny_4[NW-1] ? NW'(-ny_4) : NW'(ny_4);
      dm_5    <= den_4[DNW-1] ? DNW'(-den_4) : DNW'(den_4);

      // Range check: a quotient of 2^24 or more can only saturate.
      rx[0]   <= RW'(ax_5);
      ry[0]   <= RW'(ay_5);
      qx[0]   <= '0;
      qy[0]   <= '0;
      dm[0]   <= dm_5;
      negx[0] <= nxneg_5 ^ dneg_5;
      negy[0] <= nyneg_5 ^ dneg_5;
      ovx[0]  <= RW'(ax_5) >= dshift;
      ovy[0]  <= RW'(ay_5) >= dshift;
      dz[0]   <= dzero_5;
    end
  end

  // Restoring division, one quotient bit per stage, most significant first.
  for (genvar j = 0; j < QB; j++) begin : g_div
    localparam int SH = QB - 1 - j;
    logic [RW-1:0] dsh;
    logic          gex, gey;

    always_comb begin
      dsh = RW'(dm[j]) << SH;
      gex = rx[j] >= dsh;
      gey = ry[j] >= dsh;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vd[j+1] <= 1'b0;
      end else if (adv) begin
        vd[j+1] <= vd[j];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rx[j+1]   <= gex ? rx[j] - dsh : rx[j];
        ry[j+1]   <= gey ? ry[j] - dsh : ry[j];
        qx[j+1]   <= qx[j] | (QB'(gex) << SH);
        qy[j+1]   <= qy[j] | (QB'(gey) << SH);
        dm[j+1]   <= dm[j];
        negx[j+1] <= negx[j];
        negy[j+1] <= negy[j];
        ovx[j+1]  <= ovx[j];
        ovy[j+1]  <= ovy[j];
        dz[j+1]   <= dz[j];
      end
    end
  end

  // Sign, saturation and status of the finished quotients.
  always_comb begin
    satx = ovx[QB] || (negx[QB] ? (qx[QB] > 24'h800000) : (qx[QB] > 24'h7FFFFF));
    saty = ovy[QB] || (negy[QB] ? (qy[QB] > 24'h800000) : (qy[QB] > 24'h7FFFFF));
    if (dz[QB]) begin
      res.x_mm   = '0;
      res.y_mm   = '0;
      res.status = STATUS_ZERO_DEN;
    end else begin
      if (satx) begin
        res.x_mm = negx[QB] ? 24'sh800000 : 24'sh7FFFFF;
      end else begin
        res.x_mm = negx[QB] ? $signed(-qx[QB]) : $signed(qx[QB]);
      end
      if (saty) begin
        res.y_mm = negy[QB] ? 24'sh800000 : 24'sh7FFFFF;
      end else begin
        res.y_mm = negy[QB] ? $signed(-qy[QB]) : $signed(qy[QB]);
      end
      res.status = (satx || saty) ? STATUS_SATURATED : STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data <= res;
    end
  end

endmodule
